[hdl/ps2mpt_pkg.sv]
package ps2mpt_pkg;

  // Resolution registers
  localparam int unsigned RES_W = 13;
  localparam logic [RES_W-1:0] SCREEN_WIDTH_RESET  = 13'd1024;
  localparam logic [RES_W-1:0] SCREEN_HEIGHT_RESET = 13'd768;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  // Header bit positions
  localparam int unsigned HDR_LEFT   = 0;
  localparam int unsigned HDR_RIGHT  = 1;
  localparam int unsigned HDR_MIDDLE = 2;
  localparam int unsigned HDR_SYNC   = 3;
  localparam int unsigned HDR_XSIGN  = 4;
  localparam int unsigned HDR_YSIGN  = 5;

  // Byte position within a packet
  typedef enum logic [1:0] {
    POS_HEADER = 2'd0,
    POS_XMOVE  = 2'd1,
    POS_YMOVE  = 2'd2
  } byte_pos_t;

  // One assembled three-byte packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] x_move;
    logic [7:0] y_move;
  } packet_t;

  // Packet request from the assembler to the queue
  typedef struct packed {
    logic    valid;
    packet_t pkt;
  } packet_req_t;

  // Queue status towards both sides
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/ps2mpt_front.sv]
module ps2mpt_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic [7:0]               rx_byte,
  input  logic                     rx_error,
  output ps2mpt_pkg::packet_req_t  pkt_req
);
  import ps2mpt_pkg::*;

  logic [7:0] header_byte;
  logic [7:0] x_move_byte;
  byte_pos_t  byte_count;
  logic       syncing;

  logic take;
  logic relock;
  logic hold_off;

  // Classify the incoming byte
  assign take     = in_valid && !in_stall && !rx_error;
  assign relock   = syncing && rx_byte[HDR_SYNC];
  assign hold_off = syncing && !rx_byte[HDR_SYNC] && (byte_count == POS_HEADER);

  // Request a packet on its third byte
  always_comb begin
    pkt_req.valid      = take && !relock && !hold_off && (byte_count == POS_YMOVE);
    pkt_req.pkt.header = header_byte;
    pkt_req.pkt.x_move = x_move_byte;
    pkt_req.pkt.y_move = rx_byte;
  end

  // Gather bytes and track lock
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= 8'd0;
      x_move_byte <= 8'd0;
      byte_count  <= POS_HEADER;
      syncing     <= 1'b1;
    end else if (take) begin
      if (relock) begin
        header_byte <= rx_byte;
        byte_count  <= POS_XMOVE;
      end else if (!hold_off) begin
        case (byte_count)
          POS_HEADER: begin
            header_byte <= rx_byte;
            byte_count  <= POS_XMOVE;
          end
          POS_XMOVE: begin
            x_move_byte <= rx_byte;
            byte_count  <= POS_YMOVE;
          end
          default: begin
            byte_count <= POS_HEADER;
            syncing    <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

[hdl/ps2mpt_queue.sv]
module ps2mpt_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  ps2mpt_pkg::packet_req_t    pkt_req,
  input  logic                       pop,
  output ps2mpt_pkg::packet_t        head,
  output ps2mpt_pkg::queue_status_t  status
);
  import ps2mpt_pkg::*;

  packet_t    entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  logic do_push;
  logic do_pop;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign do_push      = pkt_req.valid && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = entry[rd_ptr];

  // Store packets
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= pkt_req.pkt;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/ps2mpt_back.sv]
module ps2mpt_back #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mpt_pkg::RES_W-1:0]     cfg_data,
  input  ps2mpt_pkg::packet_t             head,
  input  ps2mpt_pkg::queue_status_t       status,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [COORD_WIDTH-1:0]          pos_x,
  output logic [COORD_WIDTH-1:0]          pos_y,
  output logic                            button_left,
  output logic                            button_middle,
  output logic                            button_right
);
  import ps2mpt_pkg::*;

  // Working width: holds the resolution and any cursor plus move
  localparam int unsigned SUM_W = (COORD_WIDTH + 2 > RES_W + 1) ? COORD_WIDTH + 2 : RES_W + 1;
  localparam logic [SUM_W-1:0] CAP = SUM_W'(1) << COORD_WIDTH;

  logic [RES_W-1:0]       screen_width;
  logic [RES_W-1:0]       screen_height;
  logic [COORD_WIDTH-1:0] cursor_x;
  logic [COORD_WIDTH-1:0] cursor_y;

  logic [SUM_W-1:0]       limit_x;
  logic [SUM_W-1:0]       limit_y;
  logic [SUM_W-1:0]       dx;
  logic [SUM_W-1:0]       dy;
  logic [SUM_W-1:0]       sum_x;
  logic [SUM_W-1:0]       sum_y;
  logic [COORD_WIDTH-1:0] cursor_x_next;
  logic [COORD_WIDTH-1:0] cursor_y_next;

  // Write resolution registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RESET;
      screen_height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Limit each resolution to 1..2^COORD_WIDTH
  always_comb begin
    if (screen_width == '0) begin
      limit_x = SUM_W'(1);
    end else if (SUM_W'(screen_width) > CAP) begin
      limit_x = CAP;
    end else begin
      limit_x = SUM_W'(screen_width);
    end
    if (screen_height == '0) begin
      limit_y = SUM_W'(1);
    end else if (SUM_W'(screen_height) > CAP) begin
      limit_y = CAP;
    end else begin
      limit_y = SUM_W'(screen_height);
    end
  end

  // Apply moves: x added, y subtracted
  always_comb begin
    dx    = {{(SUM_W-8){head.header[HDR_XSIGN]}}, head.x_move};
    dy    = {{(SUM_W-8){head.header[HDR_YSIGN]}}, head.y_move};
    sum_x = SUM_W'(cursor_x) + dx;
    sum_y = SUM_W'(cursor_y) - dy;
  end

  // Clamp to the screen
  always_comb begin
    if (sum_x[SUM_W-1]) begin
      cursor_x_next = '0;
    end else if (sum_x >= limit_x) begin
      cursor_x_next = COORD_WIDTH'(limit_x - SUM_W'(1));
    end else begin
      cursor_x_next = sum_x[COORD_WIDTH-1:0];
    end
    if (sum_y[SUM_W-1]) begin
      cursor_y_next = '0;
    end else if (sum_y >= limit_y) begin
      cursor_y_next = COORD_WIDTH'(limit_y - SUM_W'(1));
    end else begin
      cursor_y_next = sum_y[COORD_WIDTH-1:0];
    end
  end

  // Take a packet when the output register is free
  assign pop = !status.empty && (!out_valid || !out_stall);

  // Hold cursor and result
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x  <= '0;
      cursor_y  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cursor_x  <= cursor_x_next;
        cursor_y  <= cursor_y_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pos_x         <= cursor_x_next;
      pos_y         <= cursor_y_next;
      button_left   <= head.header[HDR_LEFT];
      button_middle <= head.header[HDR_MIDDLE];
      button_right  <= head.header[HDR_RIGHT];
    end
  end

endmodule

[hdl/ps2_mouse_packet_tracker.sv]
// PS/2 mouse packet tracker: one byte per cycle at the input unless stalled.
// The third byte of a packet pushes it into the queue; the cursor unit then
// pops it, adds and clamps, and registers the result when its output is free.
// One packet per cycle at the cursor unit while the output does not stall;
// a two-entry packet queue separates the assembler from the output stall.
// Reset (rst, synchronous): cursor at 0,0, resolution 1024 by 768, resync.
module ps2_mouse_packet_tracker #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       rx_byte,
  input  logic                             rx_error,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [COORD_WIDTH-1:0]           pos_x,
  output logic [COORD_WIDTH-1:0]           pos_y,
  output logic                             button_left,
  output logic                             button_middle,
  output logic                             button_right,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ps2mpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ps2mpt_pkg::RES_W-1:0]     cfg_data
);
  import ps2mpt_pkg::*;

  packet_req_t   pkt_req;
  packet_t       head;
  queue_status_t status;
  logic          pop;

  // Stall bytes while the packet queue is full
  assign in_stall  = status.full;
  assign cfg_ready = 1'b1;

  ps2mpt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .rx_error (rx_error),
    .pkt_req  (pkt_req)
  );

  ps2mpt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .pkt_req (pkt_req),
    .pop     (pop),
    .head    (head),
    .status  (status)
  );

  ps2mpt_back #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .button_left   (button_left),
    .button_middle (button_middle),
    .button_right  (button_right)
  );

endmodule
